FILE: rtl/alle_pkg.sv
`timescale 1ns / 1ps

package alle_pkg;

  localparam int POOL_DEPTH_DEF    = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Fixed field widths of the two channels
  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FIRST = 3'd0,
    CMD_ADD_AFTER = 3'd1,
    CMD_ADD_LAST  = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_AFTER = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_TRAVERSE  = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_FULL          = 3'd1,
    ST_EMPTY         = 3'd2,
    ST_NOTHING_AFTER = 3'd3,
    ST_BAD_POSITION  = 3'd4
  } status_e;

  // Datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LATCH     = 4'd1,
    OP_START     = 4'd2,
    OP_ERR       = 4'd3,
    OP_SCAN      = 4'd4,
    OP_INS_FIRST = 4'd5,
    OP_INS_NEW   = 4'd6,
    OP_INS_LINK  = 4'd7,
    OP_DEL_FIRST = 4'd8,
    OP_CHK_NEXT  = 4'd9,
    OP_UNLINK    = 4'd10,
    OP_ADVANCE   = 4'd11,
    OP_EMIT      = 4'd12,
    OP_EMIT_TRAV = 4'd13
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e err;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic pos_ok;
    logic full;
    logic empty;
    logic single;
    logic rd_tail;
    logic scan_hit;
    logic walk_end;
    logic trav_fin;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/alle_if.sv
`timescale 1ns / 1ps

interface alle_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [alle_pkg::CMD_W-1:0]   command;
  logic [alle_pkg::POS_W-1:0]   position;
  logic [alle_pkg::DATA_W-1:0]  entry_data;

  modport source (output valid, command, position, entry_data, input ready);
  modport sink   (input valid, command, position, entry_data, output ready);
endinterface

interface alle_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [alle_pkg::STATUS_W-1:0]  status;
  logic [alle_pkg::SLOT_W-1:0]    slot;
  logic [alle_pkg::DATA_W-1:0]    payload;
  logic [alle_pkg::COUNT_W-1:0]   entry_count;
  logic                           last;

  modport source (output valid, status, slot, payload, entry_count, last, input ready);
  modport sink   (input valid, status, slot, payload, entry_count, last, output ready);
endinterface

FILE: rtl/alle_dp.sv
`timescale 1ns / 1ps

module alle_dp #(
  parameter int POOL_DEPTH    = alle_pkg::POOL_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = alle_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alle_pkg::dp_cmd_t             ctl_i,
  output alle_pkg::dp_stat_t            stat_o,
  input  logic [alle_pkg::CMD_W-1:0]    command_i,
  input  logic [alle_pkg::POS_W-1:0]    position_i,
  input  logic [alle_pkg::DATA_W-1:0]   entry_data_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [alle_pkg::STATUS_W-1:0] status_o,
  output logic [alle_pkg::SLOT_W-1:0]   slot_o,
  output logic [alle_pkg::DATA_W-1:0]   payload_o,
  output logic [alle_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                          last_o
);

  localparam int SW      = $clog2(POOL_DEPTH);
  localparam int CW      = $clog2(POOL_DEPTH + 1);
  localparam int PW      = PAYLOAD_WIDTH;
  localparam int SlotW   = alle_pkg::SLOT_W;
  localparam int CountW  = alle_pkg::COUNT_W;
  localparam int DataW   = alle_pkg::DATA_W;
  localparam int PosW    = alle_pkg::POS_W;
  localparam logic [SW-1:0] LastSlot  = SW'(POOL_DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(POOL_DEPTH);

  typedef struct packed {
    logic          tail;
    logic [SW-1:0] next;
  } link_t;

  // List state
  logic [POOL_DEPTH-1:0] used_q;
  logic [SW-1:0]         head_q;
  logic [CW-1:0]         size_q;

  // Working registers
  alle_pkg::cmd_e        cmd_q;
  logic [PosW-1:0]       pos_q;
  logic [PW-1:0]         data_q;
  logic [SW-1:0]         free_q;
  logic [SW-1:0]         cur_q;
  logic [SW-1:0]         prev_q;
  logic [CW-1:0]         steps_q;
  alle_pkg::status_e     status_q;
  logic [SlotW-1:0]      slot_q;

  // Link and payload stores
  link_t                 link_mem [POOL_DEPTH];
  logic [PW-1:0]         pay_mem  [POOL_DEPTH];
  link_t                 link_rd_q;
  logic [PW-1:0]         pay_rd_q;

  // Output register
  logic                  out_valid_q;
  logic                  out_valid_d;
  alle_pkg::status_e     out_status_q;
  logic [SlotW-1:0]      out_slot_q;
  logic [DataW-1:0]      out_payload_q;
  logic [CountW-1:0]     out_count_q;
  logic                  out_last_q;

  logic [SW-1:0]         pos_idx;
  logic                  pos_ok;
  logic                  use_pos;
  logic [SW-1:0]         start_slot;
  logic                  scan_hit;
  logic                  trav_fin;
  logic                  out_free;
  logic [63:0]           pay_ext;

  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic                  link_we;
  logic [SW-1:0]         link_wa;
  link_t                 link_wd;
  logic                  pay_we;

  assign pos_idx    = SW'(pos_q);
  assign pos_ok     = (32'(pos_q) < 32'(POOL_DEPTH)) && used_q[pos_idx];
  assign use_pos    = (cmd_q == alle_pkg::CMD_ADD_AFTER) || (cmd_q == alle_pkg::CMD_DEL_AFTER);
  assign start_slot = use_pos ? pos_idx : head_q;
  assign scan_hit   = !used_q[free_q] || (free_q == LastSlot);
  assign trav_fin   = link_rd_q.tail || ((steps_q + CW'(1)) == size_q);
  assign out_free   = !out_valid_q || rsp_ready_i;
  assign pay_ext    = 64'(pay_rd_q);

  // Load on an emit, otherwise hold until the sink takes the item
  assign out_valid_d = (ctl_i.op == alle_pkg::OP_EMIT) ||
                       (ctl_i.op == alle_pkg::OP_EMIT_TRAV) ||
                       (out_valid_q && !rsp_ready_i);

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.pos_ok   = pos_ok;
    stat_o.full     = (size_q == FullCount);
    stat_o.empty    = (size_q == '0);
    stat_o.single   = (size_q == CW'(1));
    stat_o.rd_tail  = link_rd_q.tail;
    stat_o.scan_hit = scan_hit;
    stat_o.walk_end = (steps_q == FullCount);
    stat_o.trav_fin = trav_fin;
    stat_o.out_free = out_free;
  end

  // Store port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = link_rd_q.next;
    link_we = 1'b0;
    link_wa = free_q;
    link_wd = link_rd_q;
    pay_we  = 1'b0;
    case (ctl_i.op)
      alle_pkg::OP_START: begin
        rd_en   = 1'b1;
        rd_addr = start_slot;
      end
      alle_pkg::OP_CHK_NEXT, alle_pkg::OP_ADVANCE, alle_pkg::OP_EMIT_TRAV: begin
        rd_en = 1'b1;
      end
      alle_pkg::OP_INS_FIRST: begin
        link_we = 1'b1;
        link_wd = '{tail: (size_q == '0), next: head_q};
        pay_we  = 1'b1;
      end
      alle_pkg::OP_INS_NEW: begin
        link_we = 1'b1;
        pay_we  = 1'b1;
      end
      alle_pkg::OP_INS_LINK: begin
        link_we = 1'b1;
        link_wa = cur_q;
        link_wd = '{tail: 1'b0, next: free_q};
      end
      alle_pkg::OP_UNLINK: begin
        link_we = 1'b1;
        link_wa = prev_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (pay_we) begin
      pay_mem[free_q] <= data_q;
    end
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr];
      pay_rd_q  <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      head_q      <= '0;
      size_q      <= '0;
      cmd_q       <= alle_pkg::CMD_ADD_FIRST;
      free_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      steps_q     <= '0;
      status_q    <= alle_pkg::ST_OK;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (ctl_i.op)
        alle_pkg::OP_LATCH: begin
          cmd_q  <= alle_pkg::cmd_e'(command_i);
          free_q <= '0;
        end
        alle_pkg::OP_START: begin
          cur_q   <= start_slot;
          prev_q  <= start_slot;
          steps_q <= '0;
        end
        alle_pkg::OP_ERR: begin
          status_q <= ctl_i.err;
          if ((ctl_i.err == alle_pkg::ST_BAD_POSITION) ||
              (ctl_i.err == alle_pkg::ST_NOTHING_AFTER)) begin
            slot_q <= SlotW'(pos_q);
          end else begin
            slot_q <= '0;
          end
        end
        alle_pkg::OP_SCAN: begin
          if (!scan_hit) begin
            free_q <= free_q + SW'(1);
          end
        end
        alle_pkg::OP_INS_FIRST: begin
          used_q[free_q] <= 1'b1;
          head_q         <= free_q;
          size_q         <= size_q + CW'(1);
          status_q       <= alle_pkg::ST_OK;
          slot_q         <= SlotW'(free_q);
        end
        alle_pkg::OP_INS_NEW: begin
          used_q[free_q] <= 1'b1;
        end
        alle_pkg::OP_INS_LINK: begin
          size_q   <= size_q + CW'(1);
          status_q <= alle_pkg::ST_OK;
          slot_q   <= SlotW'(free_q);
        end
        alle_pkg::OP_DEL_FIRST: begin
          if (!link_rd_q.tail) begin
            head_q <= link_rd_q.next;
          end
          used_q[head_q] <= 1'b0;
          size_q         <= size_q - CW'(1);
          status_q       <= alle_pkg::ST_OK;
          slot_q         <= SlotW'(head_q);
        end
        alle_pkg::OP_CHK_NEXT: begin
          cur_q <= link_rd_q.next;
        end
        alle_pkg::OP_UNLINK: begin
          used_q[cur_q] <= 1'b0;
          size_q        <= size_q - CW'(1);
          status_q      <= alle_pkg::ST_OK;
          slot_q        <= SlotW'(cur_q);
        end
        alle_pkg::OP_ADVANCE: begin
          prev_q  <= cur_q;
          cur_q   <= link_rd_q.next;
          steps_q <= steps_q + CW'(1);
        end
        alle_pkg::OP_EMIT_TRAV: begin
          cur_q   <= link_rd_q.next;
          steps_q <= steps_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Item and result payload, no reset
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      alle_pkg::OP_LATCH: begin
        pos_q  <= position_i;
        data_q <= PW'(entry_data_i);
      end
      alle_pkg::OP_EMIT: begin
        out_status_q  <= status_q;
        out_slot_q    <= slot_q;
        out_payload_q <= '0;
        out_count_q   <= CountW'(size_q);
        out_last_q    <= 1'b1;
      end
      alle_pkg::OP_EMIT_TRAV: begin
        out_status_q  <= alle_pkg::ST_OK;
        out_slot_q    <= SlotW'(cur_q);
        out_payload_q <= pay_ext[DataW-1:0];
        out_count_q   <= CountW'(size_q);
        out_last_q    <= trav_fin;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign payload_o     = out_payload_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

endmodule

FILE: rtl/alle_ctrl.sv
`timescale 1ns / 1ps

module alle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  alle_pkg::dp_stat_t stat_i,
  output alle_pkg::dp_cmd_t  ctl_o
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DECODE    = 12'b0000_0000_0010,
    S_WALK      = 12'b0000_0000_0100,
    S_SCAN      = 12'b0000_0000_1000,
    S_INS_FIRST = 12'b0000_0001_0000,
    S_INS_NEW   = 12'b0000_0010_0000,
    S_INS_LINK  = 12'b0000_0100_0000,
    S_DEL_FIRST = 12'b0000_1000_0000,
    S_CHK_AFTER = 12'b0001_0000_0000,
    S_UNLINK    = 12'b0010_0000_0000,
    S_TRAV      = 12'b0100_0000_0000,
    S_EMIT      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   first_mode;

  // Insert at the head for add_first, and for add_last on an empty list
  assign first_mode = (stat_i.cmd == alle_pkg::CMD_ADD_FIRST) ||
                      ((stat_i.cmd == alle_pkg::CMD_ADD_LAST) && stat_i.empty);

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ctl_o.op  = alle_pkg::OP_NONE;
    ctl_o.err = alle_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          ctl_o.op = alle_pkg::OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        case (stat_i.cmd)
          alle_pkg::CMD_ADD_FIRST: begin
            if (stat_i.full) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_FULL;
            end else begin
              state_d = S_SCAN;
            end
          end
          alle_pkg::CMD_ADD_AFTER: begin
            if (!stat_i.pos_ok) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_BAD_POSITION;
            end else if (stat_i.full) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_FULL;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = S_SCAN;
            end
          end
          alle_pkg::CMD_ADD_LAST: begin
            if (stat_i.full) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_FULL;
            end else if (stat_i.empty) begin
              state_d = S_SCAN;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = S_WALK;
            end
          end
          alle_pkg::CMD_DEL_FIRST: begin
            if (stat_i.empty) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_EMPTY;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = S_DEL_FIRST;
            end
          end
          alle_pkg::CMD_DEL_AFTER: begin
            if (!stat_i.pos_ok) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_BAD_POSITION;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = S_CHK_AFTER;
            end
          end
          alle_pkg::CMD_DEL_LAST: begin
            if (stat_i.empty) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_EMPTY;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = stat_i.single ? S_DEL_FIRST : S_WALK;
            end
          end
          alle_pkg::CMD_TRAVERSE: begin
            if (stat_i.empty) begin
              ctl_o.op  = alle_pkg::OP_ERR;
              ctl_o.err = alle_pkg::ST_EMPTY;
            end else begin
              ctl_o.op = alle_pkg::OP_START;
              state_d  = S_TRAV;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (stat_i.rd_tail || stat_i.walk_end) begin
          state_d = (stat_i.cmd == alle_pkg::CMD_ADD_LAST) ? S_SCAN : S_UNLINK;
        end else begin
          ctl_o.op = alle_pkg::OP_ADVANCE;
        end
      end
      S_SCAN: begin
        ctl_o.op = alle_pkg::OP_SCAN;
        if (stat_i.scan_hit) begin
          state_d = first_mode ? S_INS_FIRST : S_INS_NEW;
        end
      end
      S_INS_FIRST: begin
        ctl_o.op = alle_pkg::OP_INS_FIRST;
        state_d  = S_EMIT;
      end
      S_INS_NEW: begin
        ctl_o.op = alle_pkg::OP_INS_NEW;
        state_d  = S_INS_LINK;
      end
      S_INS_LINK: begin
        ctl_o.op = alle_pkg::OP_INS_LINK;
        state_d  = S_EMIT;
      end
      S_DEL_FIRST: begin
        ctl_o.op = alle_pkg::OP_DEL_FIRST;
        state_d  = S_EMIT;
      end
      S_CHK_AFTER: begin
        if (stat_i.rd_tail) begin
          ctl_o.op  = alle_pkg::OP_ERR;
          ctl_o.err = alle_pkg::ST_NOTHING_AFTER;
          state_d   = S_EMIT;
        end else begin
          ctl_o.op = alle_pkg::OP_CHK_NEXT;
          state_d  = S_UNLINK;
        end
      end
      S_UNLINK: begin
        ctl_o.op = alle_pkg::OP_UNLINK;
        state_d  = S_EMIT;
      end
      S_TRAV: begin
        if (stat_i.out_free) begin
          ctl_o.op = alle_pkg::OP_EMIT_TRAV;
          if (stat_i.trav_fin) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.op = alle_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/array_linked_list_engine.sv
// An error result passes the decode and emit states into the output register, a delete-first
//   also the delete state; traverse emits one entry per cycle unless the sink stalls.
// Add commands scan the used flags for the lowest free slot, one slot per cycle; add_last
//   and del_last first walk to the tail, one link per cycle.
// Throughput: one item at a time, the next taken once the last result of this one is loaded.
// Reset (rst_ni low, asynchronous) empties the list and the output register; the link and
//   payload stores are not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module array_linked_list_engine #(
  parameter int POOL_DEPTH    = alle_pkg::POOL_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = alle_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alle_cmd_if.sink    cmd_i,
  alle_rsp_if.source  rsp_o
);

  // Command and status between the sequencer and the datapath
  alle_pkg::dp_cmd_t  ctl;
  alle_pkg::dp_stat_t stat;
  logic               cmd_ready;

  // Sequencer: decodes the latched item and steps the datapath through the
  // walk, the free-slot scan, the relinking and the result emission.
  alle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  // Take a new item only while the sequencer is idle
  assign cmd_i.ready = cmd_ready;

  // Datapath: used flags, head and size, the link and payload stores and the
  // output register, which holds a result while the sink stalls.
  alle_dp #(
    .POOL_DEPTH    (POOL_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .command_i     (cmd_i.command),
    .position_i    (cmd_i.position),
    .entry_data_i  (cmd_i.entry_data),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .slot_o        (rsp_o.slot),
    .payload_o     (rsp_o.payload),
    .entry_count_o (rsp_o.entry_count),
    .last_o        (rsp_o.last)
  );

endmodule

FILE: rtl/alle_checker.sv
`timescale 1ns / 1ps

module alle_checker #(
  parameter int POOL_DEPTH = alle_pkg::POOL_DEPTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [alle_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [alle_pkg::SLOT_W-1:0]   rsp_slot_i,
  input logic [alle_pkg::DATA_W-1:0]   rsp_payload_i,
  input logic [alle_pkg::COUNT_W-1:0]  rsp_count_i,
  input logic                          rsp_last_i
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_slot_i) && $stable(rsp_payload_i) && $stable(rsp_count_i) &&
      $stable(rsp_last_i))
    else $error("result changed while stalled");

  // One item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("second item taken while busy");

  // A failed command gives a single result with no payload
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != alle_pkg::ST_OK) |-> rsp_last_i && (rsp_payload_i == '0))
    else $error("error result not final or carries payload");

  // The list never holds more entries than the pool
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (POOL_DEPTH >= 32) || (32'(rsp_count_i) <= 32'(POOL_DEPTH)))
    else $error("entry count beyond pool depth");

endmodule

bind array_linked_list_engine alle_checker #(
  .POOL_DEPTH (POOL_DEPTH)
) u_alle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_slot_i    (rsp_o.slot),
  .rsp_payload_i (rsp_o.payload),
  .rsp_count_i   (rsp_o.entry_count),
  .rsp_last_i    (rsp_o.last)
);
